// ===== sv/sia_pkg.sv =====
`timescale 1ns / 1ps
// shared types, op and status codes for the stack integer alu
// no dependencies

package sia_pkg;

    // word and field widths
    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int DEPTH_W = 7;

    // default stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // divider iterations, one quotient bit each
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // op codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [ST_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic            load;
        logic            push;
        logic            clear;
        logic            rd_sec;
        logic            wr_alu;
        logic            div_start;
        logic            div_wr;
        logic            st_we;
        logic [ST_W-1:0] st_val;
        logic            out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic            full;
        logic            short_stack;
        logic            top_zero;
        logic            div_done;
        logic            out_free;
        logic [OP_W-1:0] op;
    } t_sts;

endpackage

// ===== sv/sia_intf.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for the stack integer alu
// depends on sia_pkg

interface sia_in_if;
    logic                               valid;
    logic                               ready;
    logic [sia_pkg::OP_W-1:0]           op;
    logic signed [sia_pkg::WORD_W-1:0]  push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface sia_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sia_pkg::WORD_W-1:0]  top_value;
    logic [sia_pkg::ST_W-1:0]           status;
    logic [sia_pkg::DEPTH_W-1:0]        depth_after;

    modport source (output valid, output top_value, output status, output depth_after,
                    input ready);
    modport sink   (input valid, input top_value, input status, input depth_after,
                    output ready);
endinterface

// ===== sv/stack_integer_alu.sv =====
`timescale 1ns / 1ps
// top level of the stack integer alu: controller plus datapath
// depends on sia_pkg, sia_intf, sia_ctrl, sia_dp
//
//   port    dir  beat
//   i_cmd   in   op, push_value
//   o_res   out  top_value, status, depth_after
//
// push, error and unused ops pass through exec and fin, add/sub/mul also through rd,
// div and mod also wait in the div state on the 32-step bit-serial divider
// reset is synchronous, active low, and leaves the stack empty
// a new beat is taken while the last result waits in the output register;
// a result stalled past that holds the controller in its final state

module stack_integer_alu #(
    parameter int STACK_DEPTH = sia_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sia_in_if.sink     i_cmd,
    sia_out_if.source  o_res
);

    sia_pkg::t_cmd w_cmd;
    sia_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_cmd.ready = w_in_ready;

    // controller
    sia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    sia_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_cmd.op),
        .i_push_value  (i_cmd.push_value),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_top_value   (o_res.top_value),
        .o_status      (o_res.status),
        .o_depth_after (o_res.depth_after)
    );

endmodule

// ===== sv/sia_div.sv =====
`timescale 1ns / 1ps
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on sia_pkg

module sia_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_want_rem,
    input  logic [sia_pkg::WORD_W-1:0] i_dividend,
    input  logic [sia_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sia_pkg::WORD_W-1:0] o_result
);

    localparam int W = sia_pkg::WORD_W;

    logic                          r_busy;
    logic                          r_done;
    logic [sia_pkg::STEP_W-1:0]    r_step;
    logic [W-1:0]                  r_rem;
    logic [W-1:0]                  r_quo;
    logic [W-1:0]                  r_mb;
    logic                          r_neg_a;
    logic                          r_neg_b;
    logic                          r_want_rem;

    logic [W:0]                    w_shift;
    logic [W:0]                    w_diff;
    logic [W-1:0]                  w_ma;
    logic [W-1:0]                  w_mb;

    // operand magnitudes
    assign w_ma = i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
    assign w_mb = i_divisor[W-1]  ? (W'(0) - i_divisor)  : i_divisor;

    // restoring step: shift in next dividend bit, trial subtract
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_mb};

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == sia_pkg::STEP_W'(sia_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem      <= '0;
            r_quo      <= w_ma;
            r_mb       <= w_mb;
            r_neg_a    <= i_dividend[W-1];
            r_neg_b    <= i_divisor[W-1];
            r_want_rem <= i_want_rem;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    // sign fixup
    always_comb begin
        if (r_want_rem) begin
            o_result = r_neg_a ? (W'(0) - r_rem) : r_rem;
        end else begin
            o_result = (r_neg_a != r_neg_b) ? (W'(0) - r_quo) : r_quo;
        end
    end

    assign o_done = r_done;

endmodule

// ===== sv/sia_dp.sv =====
`timescale 1ns / 1ps
// datapath: stack memory, top register, count, alu, divider, result register
// depends on sia_pkg and sia_div

module sia_dp #(
    parameter int STACK_DEPTH = sia_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sia_pkg::t_cmd               i_cmd,
    output sia_pkg::t_sts               o_sts,
    input  logic [sia_pkg::OP_W-1:0]    i_op,
    input  logic [sia_pkg::WORD_W-1:0]  i_push_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sia_pkg::WORD_W-1:0]  o_top_value,
    output logic [sia_pkg::ST_W-1:0]    o_status,
    output logic [sia_pkg::DEPTH_W-1:0] o_depth_after
);

    localparam int W     = sia_pkg::WORD_W;
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [sia_pkg::OP_W-1:0]    r_op;
    logic [W-1:0]                r_pv;
    logic [CNT_W-1:0]            r_count;
    logic [W-1:0]                r_top;
    logic [W-1:0]                r_sec;
    logic [sia_pkg::ST_W-1:0]    r_status;
    logic                        r_out_valid;
    logic [W-1:0]                r_out_top;
    logic [sia_pkg::ST_W-1:0]    r_out_status;
    logic [sia_pkg::DEPTH_W-1:0] r_out_depth;

    logic [W-1:0]                r_mem [STACK_DEPTH];

    logic [CNT_W-1:0]            w_cnt_m1;
    logic [CNT_W-1:0]            w_cnt_m2;
    logic [W-1:0]                w_alu;
    logic [W-1:0]                w_prod;
    logic                        w_div_done;
    logic [W-1:0]                w_div_res;

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_cnt_m2 = r_count - CNT_W'(2);

    // add, sub and low word of the product
    assign w_prod = r_sec * r_top;
    always_comb begin
        case (r_op)
            sia_pkg::OP_ADD: w_alu = r_sec + r_top;
            sia_pkg::OP_SUB: w_alu = r_sec - r_top;
            default:         w_alu = w_prod;
        endcase
    end

    // divider
    sia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_want_rem (r_op == sia_pkg::OP_MOD),
        .i_dividend (r_sec),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_result   (w_div_res)
    );

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_pv <= i_push_value;
        end
    end

    // stack memory, holds every entry below the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_count != '0) begin
            r_mem[w_cnt_m1[AW-1:0]] <= r_top;
        end
        if (i_cmd.rd_sec) begin
            r_sec <= r_mem[w_cnt_m2[AW-1:0]];
        end
    end

    // top of stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= r_pv;
        end else if (i_cmd.wr_alu) begin
            r_top <= w_alu;
        end else if (i_cmd.div_wr) begin
            r_top <= w_div_res;
        end
    end

    // entry count and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= sia_pkg::ST_OK;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.wr_alu || i_cmd.div_wr) begin
                r_count <= w_cnt_m1;
            end
            if (i_cmd.st_we) begin
                r_status <= i_cmd.st_val;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_top    <= (r_count != '0) ? r_top : '0;
            r_out_status <= r_status;
            r_out_depth  <= sia_pkg::DEPTH_W'(r_count);
        end
    end

    // status back to controller
    assign o_sts.full        = (r_count == CNT_W'(STACK_DEPTH));
    assign o_sts.short_stack = (r_count < CNT_W'(2));
    assign o_sts.top_zero    = (r_top == '0);
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_free    = !r_out_valid || i_ready;
    assign o_sts.op          = r_op;

    assign o_valid       = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_status      = r_out_status;
    assign o_depth_after = r_out_depth;

endmodule

// ===== sv/sia_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences one op at a time through the datapath
// depends on sia_pkg

module sia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sia_pkg::t_sts i_sts,
    output sia_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_divide;

    assign w_divide = (i_sts.op == sia_pkg::OP_DIV) || (i_sts.op == sia_pkg::OP_MOD);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.st_we  = 1'b1;
                o_cmd.st_val = sia_pkg::ST_OK;
                n_state      = S_FIN;
                unique case (i_sts.op) inside
                    sia_pkg::OP_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.st_val = sia_pkg::ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    sia_pkg::OP_ADD, sia_pkg::OP_SUB, sia_pkg::OP_MUL,
                    sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
                        if (i_sts.short_stack) begin
                            o_cmd.clear  = 1'b1;
                            o_cmd.st_val = sia_pkg::ST_SHORT;
                        end else if (w_divide && i_sts.top_zero) begin
                            o_cmd.clear  = 1'b1;
                            o_cmd.st_val = sia_pkg::ST_DIVZERO;
                        end else begin
                            o_cmd.rd_sec = 1'b1;
                            n_state      = S_RD;
                        end
                    end
                    default: begin
                        // unused codes leave the stack alone
                    end
                endcase
            end
            S_RD: begin
                if (w_divide) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.wr_alu = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
